/* hw/rtl/wts_pkg.sv */
// Shared constants and status codes for the Welch t statistic engine.
package wts_pkg;

   localparam int DEF_MAX_SAMPLES = 1024;
   localparam int SAMPLE_W        = 24;
   localparam int RESULT_W        = 32;
   localparam int STATUS_W        = 2;
   localparam int WIDE_W          = 192;
   localparam int OPER_W          = 64;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FEW      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_VAR = 2'd2;

endpackage

/* hw/rtl/welch_t_statistic_engine.sv */
// Welch two-sample t statistic engine: accumulators and shared-unit sequencer.
//
//  channel | direction | tdata               | tuser          | tlast
//  req_    | in        | sample_value [23:0] | group_label    | last_sample
//  rsp_    | out       | neg_abs_t [31:0]    | status [1:0]   | -
//
// A sample without the last flag is taken one per cycle.
// A last sample starts the sequencer: up to 15 shift-add products (each over
// its significant multiplier bits, at most 45), 62 restoring divide steps and
// 32 square root steps, all on one 192-bit datapath. A group with under two
// samples goes straight to the result; req_tready stays low throughout.
// The result sits in an output register; a stalled rsp_ holds the sequencer.
// Reset is synchronous, active high, and clears counts, sums and control.
module welch_t_statistic_engine
   import wts_pkg::*;
#(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] sample_value
   input  logic        req_tuser,   // [0] group_label
   input  logic        req_tlast,   // last_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] neg_abs_t
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = SAMPLE_W + $clog2(MAX_SAMPLES);
   localparam int SQ_W  = 2 * SAMPLE_W + $clog2(MAX_SAMPLES);

   typedef enum logic [4:0] {
      ST_IDLE, ST_CHK, ST_MUL,
      ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
      ST_P9, ST_P10, ST_P11, ST_P12, ST_P13, ST_P14, ST_P15, ST_P16,
      ST_DIV, ST_SQRT, ST_FIN
   } state_type;

   state_type                state_ff, ret_ff, mul_ret;
   logic [CNT_W-1:0]         cnt0_ff, cnt1_ff;
   logic signed [SUM_W-1:0]  sum0_ff, sum1_ff;
   logic [SQ_W-1:0]          sq0_ff, sq1_ff;
   logic [WIDE_W-1:0]        a_ff, b_ff, acc_ff, mc_ff;
   logic [OPER_W-1:0]        mp_ff, q_ff, r_ff, sb_ff;
   logic [5:0]               cnt_ff;
   logic [RESULT_W-1:0]      mag_ff;
   logic [STATUS_W-1:0]      stat_ff;
   logic                     rsp_valid_ff;
   logic [RESULT_W-1:0]      rsp_data_ff;
   logic [STATUS_W-1:0]      rsp_user_ff;

   logic                     accept;
   logic signed [SAMPLE_W-1:0] smp;
   logic [2*SAMPLE_W-1:0]    smp_sq;
   logic                     mul_go;
   logic [WIDE_W-1:0]        mul_x, acc_sum, diff, d_abs, lim;
   logic [OPER_W-1:0]        mul_y, abs0, abs1, sq_try;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign smp        = signed'(req_tdata);
   assign smp_sq     = 48'(smp * smp);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // magnitudes of the sums, zero-extended to the multiplier operand width
   assign abs0 = OPER_W'(sum0_ff[SUM_W-1] ? -sum0_ff : sum0_ff);
   assign abs1 = OPER_W'(sum1_ff[SUM_W-1] ? -sum1_ff : sum1_ff);

   // shared wide datapath
   assign acc_sum = acc_ff + mc_ff;
   assign diff    = a_ff - acc_ff;
   assign d_abs   = a_ff[WIDE_W-1] ? (WIDE_W'(0) - a_ff) : a_ff;
   assign lim     = b_ff << 62;
   assign sq_try  = r_ff + sb_ff;

   // pick the operands of the next product
   always_comb begin
      mul_go  = 1'b0;
      mul_x   = '0;
      mul_y   = '0;
      mul_ret = ST_IDLE;
      unique case (state_ff)
         ST_CHK: begin
            mul_go = !((cnt0_ff < CNT_W'(2)) || (cnt1_ff < CNT_W'(2)));
            mul_x = WIDE_W'(sq0_ff); mul_y = OPER_W'(cnt0_ff); mul_ret = ST_P1;
         end
         ST_P1: begin
            mul_go = 1'b1; mul_x = WIDE_W'(abs0); mul_y = abs0; mul_ret = ST_P2;
         end
         ST_P2: begin
            mul_go = 1'b1; mul_x = WIDE_W'(cnt1_ff); mul_y = OPER_W'(cnt1_ff);
            mul_ret = ST_P3;
         end
         ST_P3: begin
            mul_go = 1'b1; mul_x = acc_ff; mul_y = OPER_W'(cnt1_ff - CNT_W'(1));
            mul_ret = ST_P4;
         end
         ST_P4: begin
            mul_go = 1'b1; mul_x = a_ff; mul_y = acc_ff[OPER_W-1:0]; mul_ret = ST_P5;
         end
         ST_P5: begin
            mul_go = 1'b1; mul_x = WIDE_W'(sq1_ff); mul_y = OPER_W'(cnt1_ff);
            mul_ret = ST_P6;
         end
         ST_P6: begin
            mul_go = 1'b1; mul_x = WIDE_W'(abs1); mul_y = abs1; mul_ret = ST_P7;
         end
         ST_P7: begin
            mul_go = 1'b1; mul_x = WIDE_W'(cnt0_ff); mul_y = OPER_W'(cnt0_ff);
            mul_ret = ST_P8;
         end
         ST_P8: begin
            mul_go = 1'b1; mul_x = acc_ff; mul_y = OPER_W'(cnt0_ff - CNT_W'(1));
            mul_ret = ST_P9;
         end
         ST_P9: begin
            mul_go = 1'b1; mul_x = a_ff; mul_y = acc_ff[OPER_W-1:0]; mul_ret = ST_P10;
         end
         ST_P10: begin
            mul_go = 1'b1;
            mul_x = {{(WIDE_W-SUM_W){sum0_ff[SUM_W-1]}}, sum0_ff};
            mul_y = OPER_W'(cnt1_ff); mul_ret = ST_P11;
         end
         ST_P11: begin
            mul_go = (b_ff != '0);
            mul_x = {{(WIDE_W-SUM_W){sum1_ff[SUM_W-1]}}, sum1_ff};
            mul_y = OPER_W'(cnt0_ff); mul_ret = ST_P12;
         end
         ST_P13: begin
            mul_go = 1'b1; mul_x = d_abs; mul_y = d_abs[OPER_W-1:0]; mul_ret = ST_P14;
         end
         ST_P14: begin
            mul_go = 1'b1; mul_x = WIDE_W'(cnt0_ff - CNT_W'(1));
            mul_y = OPER_W'(cnt1_ff - CNT_W'(1)); mul_ret = ST_P15;
         end
         ST_P15: begin
            mul_go = 1'b1; mul_x = a_ff; mul_y = acc_ff[OPER_W-1:0]; mul_ret = ST_P16;
         end
         default: begin
            mul_go = 1'b0;
         end
      endcase
   end

   // sequencer, accumulators and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         cnt0_ff      <= '0;
         cnt1_ff      <= '0;
         sum0_ff      <= '0;
         sum1_ff      <= '0;
         sq0_ff       <= '0;
         sq1_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the word once taken, unless a new one is loaded this cycle
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mul_go) begin
            acc_ff   <= '0;
            mc_ff    <= mul_x;
            mp_ff    <= mul_y;
            ret_ff   <= mul_ret;
            state_ff <= ST_MUL;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  // accumulate unless the group is full
                  if (!req_tuser) begin
                     if (cnt0_ff < CNT_W'(MAX_SAMPLES)) begin
                        cnt0_ff <= cnt0_ff + CNT_W'(1);
                        sum0_ff <= sum0_ff + SUM_W'(smp);
                        sq0_ff  <= sq0_ff + SQ_W'(smp_sq);
                     end
                  end else if (cnt1_ff < CNT_W'(MAX_SAMPLES)) begin
                     cnt1_ff <= cnt1_ff + CNT_W'(1);
                     sum1_ff <= sum1_ff + SUM_W'(smp);
                     sq1_ff  <= sq1_ff + SQ_W'(smp_sq);
                  end
                  if (req_tlast) begin
                     state_ff <= ST_CHK;
                  end
               end
            end
            ST_CHK: begin
               if (!mul_go) begin
                  mag_ff   <= '0;
                  stat_ff  <= STATUS_FEW;
                  state_ff <= ST_FIN;
               end
            end
            ST_MUL: begin
               // shift-add one multiplier bit per cycle, stop when none left
               if (mp_ff == '0) begin
                  state_ff <= ret_ff;
               end else begin
                  if (mp_ff[0]) begin
                     acc_ff <= acc_sum;
                  end
                  mc_ff <= mc_ff << 1;
                  mp_ff <= mp_ff >> 1;
               end
            end
            ST_P1:  a_ff <= acc_ff;
            ST_P2:  a_ff <= diff;
            ST_P3:  a_ff <= a_ff;
            ST_P4:  a_ff <= a_ff;
            ST_P5:  b_ff <= acc_ff;
            ST_P6:  a_ff <= acc_ff;
            ST_P7:  a_ff <= diff;
            ST_P8:  a_ff <= a_ff;
            ST_P9:  a_ff <= a_ff;
            ST_P10: b_ff <= b_ff + acc_ff;
            ST_P11: begin
               if (b_ff == '0) begin
                  mag_ff   <= '0;
                  stat_ff  <= STATUS_ZERO_VAR;
                  state_ff <= ST_FIN;
               end else begin
                  a_ff <= acc_ff;
               end
            end
            ST_P12: begin
               a_ff     <= diff;
               state_ff <= ST_P13;
            end
            ST_P13: a_ff <= a_ff;
            ST_P14: a_ff <= acc_ff;
            ST_P15: a_ff <= a_ff;
            ST_P16: begin
               stat_ff <= STATUS_OK;
               if ((acc_ff << 32) >= lim) begin
                  mag_ff   <= RESULT_W'(64'd1 << 31);
                  state_ff <= ST_FIN;
               end else begin
                  a_ff     <= acc_ff << 32;
                  b_ff     <= b_ff << 61;
                  q_ff     <= '0;
                  cnt_ff   <= 6'd61;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               // restoring division, one quotient bit per cycle
               if (a_ff >= b_ff) begin
                  a_ff <= a_ff - b_ff;
                  q_ff <= q_ff | (OPER_W'(1) << cnt_ff);
               end
               b_ff <= b_ff >> 1;
               if (cnt_ff == '0) begin
                  r_ff     <= '0;
                  sb_ff    <= OPER_W'(1) << 62;
                  cnt_ff   <= 6'd31;
                  state_ff <= ST_SQRT;
               end else begin
                  cnt_ff <= cnt_ff - 6'd1;
               end
            end
            ST_SQRT: begin
               // digit-by-digit square root, two radicand bits per cycle
               if (q_ff >= sq_try) begin
                  q_ff <= q_ff - sq_try;
                  r_ff <= (r_ff >> 1) + sb_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               sb_ff <= sb_ff >> 2;
               if (cnt_ff == '0) begin
                  state_ff <= ST_FIN;
                  mag_ff   <= (q_ff >= sq_try) ? RESULT_W'((r_ff >> 1) + sb_ff)
                                               : RESULT_W'(r_ff >> 1);
               end else begin
                  cnt_ff <= cnt_ff - 6'd1;
               end
            end
            ST_FIN: begin
               // hand over the word once the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= RESULT_W'(0) - mag_ff;
                  rsp_user_ff  <= stat_ff;
                  cnt0_ff      <= '0;
                  cnt1_ff      <= '0;
                  sum0_ff      <= '0;
                  sum1_ff      <= '0;
                  sq0_ff       <= '0;
                  sq1_ff       <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* hw/rtl/wts_checker.sv */
// Port-level checks for the Welch t statistic engine, bound to the top level.
module wts_checker
   import wts_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // drop ready while a final word is being worked on
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("ready high right after a final word");

   // a flagged result carries a zero statistic
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata == '0)
      else $error("flagged result with non-zero statistic");

   // status stays within its codes
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == STATUS_OK || rsp_tuser == STATUS_FEW ||
                     rsp_tuser == STATUS_ZERO_VAR)
      else $error("unknown status code");

endmodule

bind welch_t_statistic_engine wts_checker u_wts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* dv/tb_welch_t_statistic_engine.sv */
// Testbench for the Welch t statistic engine: directed and random sample streams.
`timescale 1ns / 100ps

module tb_welch_t_statistic_engine;
   import wts_pkg::*;

   localparam int          GROUP_CAP   = DEF_MAX_SAMPLES;
   localparam int          CYCLE_LIMIT = 3_000_000;
   localparam int          RAND_WORDS  = 1250;
   localparam int          IDLE_PCT    = 38;
   localparam int          DRAIN_WAIT  = 100;
   localparam logic [23:0] VAL_MAX     = 24'h7FFFFF;
   localparam logic [23:0] VAL_MIN     = 24'h800000;

   typedef struct packed {
      logic [RESULT_W-1:0] t_stat;
      logic [STATUS_W-1:0] status;
   } welch_result_type;

   // Holds the running sums and the queue of predicted statistics
   class welch_scoreboard_type;
      int unsigned       n_grp[2];
      longint            sum_grp[2];
      longint unsigned   sq_grp[2];
      welch_result_type  due_q[$];
      int                errors;

      function new();
         clear_sums();
         errors = 0;
      endfunction

      function void clear_sums();
         for (int g = 0; g < 2; g++) begin
            n_grp[g]   = 0;
            sum_grp[g] = 0;
            sq_grp[g]  = 0;
         end
      endfunction

      // Floor square root of a value below 2^62
      function longint unsigned root_floor(longint unsigned x);
         longint unsigned r;
         longint unsigned cand;
         r = 0;
         for (int b = 31; b >= 0; b--) begin
            cand = r | (64'd1 << b);
            if (cand * cand <= x) r = cand;
         end
         return r;
      endfunction

      // n*SS - S^2, the scaled spread of one group
      function logic [255:0] spread_of(int g);
         logic [255:0] a, s;
         a = 256'(sq_grp[g]) * 256'(n_grp[g]);
         s = 256'(sum_grp[g] < 0 ? -sum_grp[g] : sum_grp[g]);
         return a - s * s;
      endfunction

      function void note_input(logic [23:0] sample, bit grp, bit lst);
         longint           v, d;
         logic [255:0]     n0, n1, den, num, lim;
         longint unsigned  mag;
         welch_result_type r;
         v = longint'($signed(sample));
         if (n_grp[grp] < GROUP_CAP) begin
            n_grp[grp]++;
            sum_grp[grp] += v;
            sq_grp[grp]  += longint'(v * v);
         end
         if (!lst) return;
         mag = 0;
         r.status = STATUS_OK;
         if (n_grp[0] < 2 || n_grp[1] < 2) begin
            r.status = STATUS_FEW;
         end else begin
            n0  = 256'(n_grp[0]);
            n1  = 256'(n_grp[1]);
            den = spread_of(0) * n1 * n1 * (n1 - 1) + spread_of(1) * n0 * n0 * (n0 - 1);
            if (den == 0) begin
               r.status = STATUS_ZERO_VAR;
            end else begin
               d   = sum_grp[0] * longint'(n_grp[1]) - sum_grp[1] * longint'(n_grp[0]);
               num = 256'(d < 0 ? -d : d);
               num = ((num * num) * (n0 - 1) * (n1 - 1)) << 32;
               lim = den << 62;
               if (num >= lim) mag = 64'd1 << 31;
               else begin
                  mag = root_floor(64'(num / den));
                  if (mag > (64'd1 << 31)) mag = 64'd1 << 31;
               end
            end
         end
         r.t_stat = RESULT_W'(-mag);
         due_q.push_back(r);
         clear_sums();
      endfunction

      function void check_result(logic [31:0] t_stat, logic [1:0] status);
         welch_result_type e;
         if (due_q.size() == 0) begin
            $display("%0t: unexpected result t=%h status=%0d", $realtime, t_stat, status);
            errors++;
            return;
         end
         e = due_q.pop_front();
         if (t_stat !== e.t_stat) begin
            $display("%0t: neg_abs_t expected %h actual %h", $realtime, e.t_stat, t_stat);
            errors++;
         end
         if (status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.status, status);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   welch_scoreboard_type sb = new();
   bit              calm = 1'b0;
   int              cycles = 0;
   int              sent = 0;

   welch_t_statistic_engine dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Stall the result side at random
   always @(negedge clock)
      rsp_tready <= reset ? 1'b0 : (calm || $urandom_range(99) >= IDLE_PCT);

   // Check every accepted result word
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);

   // Offer one sample word; called and returns at a falling edge
   task automatic send_sample(logic [23:0] v, bit grp, bit lst);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tuser  <= grp;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      sb.note_input(v, grp, lst);
      sent++;
      @(negedge clock);
   endtask

   // Withdraw the offered word and hold off until every result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.due_q.size() != 0) @(negedge clock);
   endtask

   // Random value: full range, small noise about an offset, or a constant
   function automatic logic [23:0] pick_value(int style, int offset);
      case (style)
         0:       return 24'($urandom);
         1:       return 24'(offset + $urandom_range(64) - 32);
         default: return 24'(offset);
      endcase
   endfunction

   initial begin
      int len, style, off0, off1;
      bit grp;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Too few samples: a lone last word, then one sample in a group
      send_sample(24'd5, 1'b0, 1'b1);
      send_sample(24'd100, 1'b0, 1'b0);
      send_sample(24'd7, 1'b1, 1'b0);
      send_sample(24'd9, 1'b1, 1'b1);
      // Zero pooled variance
      send_sample(24'd4096, 1'b0, 1'b0);
      send_sample(24'd4096, 1'b0, 1'b0);
      send_sample(VAL_MIN, 1'b1, 1'b0);
      send_sample(VAL_MIN, 1'b1, 1'b1);
      // Equal means
      send_sample(24'd1, 1'b0, 1'b0);
      send_sample(24'd3, 1'b0, 1'b0);
      send_sample(24'd3, 1'b1, 1'b0);
      send_sample(24'd1, 1'b1, 1'b1);
      // Extremes of the sample range
      send_sample(VAL_MAX, 1'b0, 1'b0);
      send_sample(VAL_MIN, 1'b0, 1'b0);
      send_sample(24'd0, 1'b1, 1'b0);
      send_sample(VAL_MIN, 1'b1, 1'b1);
      // Huge separation, tiny spread: saturates
      send_sample(VAL_MAX, 1'b0, 1'b0);
      send_sample(VAL_MAX - 1, 1'b0, 1'b0);
      send_sample(VAL_MIN, 1'b1, 1'b0);
      send_sample(VAL_MIN + 1, 1'b1, 1'b1);
      drain_results();

      // Full group: overfill the second group, last word lands in the full one
      for (int i = 0; i < GROUP_CAP + 4; i++) begin
         calm = (i < 300);
         send_sample(pick_value(1, 2000), 1'b1, 1'b0);
      end
      send_sample(24'd10, 1'b0, 1'b0);
      send_sample(24'd900, 1'b0, 1'b0);
      send_sample(24'd77, 1'b1, 1'b1);

      // Random vectors
      while (sent < RAND_WORDS) begin
         calm = ($urandom_range(9) == 0);
         if ($urandom_range(7) == 0) drain_results();
         len   = $urandom_range(20, 1);
         style = $urandom_range(9) < 3 ? 0 : ($urandom_range(9) == 0 ? 2 : 1);
         off0  = int'($urandom_range(4000)) - 2000;
         off1  = off0 + int'($urandom_range(40)) - 20;
         for (int i = 0; i < len; i++) begin
            grp = $urandom_range(1);
            send_sample(pick_value(style, grp ? off1 : off0), grp, i == len - 1);
         end
      end
      calm = 1'b0;
      drain_results();
      repeat (DRAIN_WAIT) @(negedge clock);
      if (sb.errors == 0 && sb.due_q.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
